FILE: sv/tfm_pkg.sv
// tfm_pkg: shared types and constants of the topic filter wildcard match unit
// used by topic_filter_wildcard_match_unit and the testbench; no dependencies
`default_nettype none

package tfm_pkg;

    // filter storage sizing
    localparam int FILTER_MAX  = 32;
    localparam int ADDR_W      = $clog2(FILTER_MAX);
    localparam int LEN_W       = $clog2(FILTER_MAX + 1);
    // bound on match steps spent on one topic byte
    localparam int GUARD_LIMIT = FILTER_MAX + 4;
    localparam int GUARD_W     = $clog2(GUARD_LIMIT + 1);

    // special characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TOPIC = 1'b1;

    // verdict codes
    localparam logic [1:0] VERDICT_OPEN    = 2'd0;
    localparam logic [1:0] VERDICT_MATCH   = 2'd1;
    localparam logic [1:0] VERDICT_NOMATCH = 2'd2;
    localparam logic [1:0] VERDICT_INVALID = 2'd3;

    // input transaction
    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
        logic       last;
    } in_t;

    // result transaction
    typedef struct packed {
        logic matched;
        logic invalid_filter;
    } out_t;

endpackage

`default_nettype wire

FILE: sv/topic_filter_wildcard_match_unit.sv
// topic_filter_wildcard_match_unit: top level of the topic filter matcher
// depends on tfm_pkg and tfm_ram
`default_nettype none

// channel  | dir | ports                         | payload
// ---------+-----+-------------------------------+------------------------------------
// input    | in  | s_valid, s_ready, s_data      | action, char_code, last (in_t)
// result   | out | m_valid, m_ready, m_data      | matched, invalid_filter (out_t)
//
// a filter load transaction is taken directly in idle; a topic byte is accepted in idle and
// then runs its match steps in the eval state, or only closes when the verdict is already fixed;
// a step reads one filter character or ends a plus level on a slash; consecutive plus
// characters chain steps, capped at GUARD_LIMIT steps plus a closing one; no new input is taken
// until the byte is done. reset clears all control state; filter ram contents need no reset
// a result that cannot enter the output register holds the unit until taken

module topic_filter_wildcard_match_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tfm_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tfm_pkg::out_t      m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [tfm_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                        load_open_reg, load_open_next;
    logic [tfm_pkg::LEN_W-1:0]   pos_reg, pos_next;
    logic                        skip_reg, skip_next;
    logic [1:0]                  verdict_reg, verdict_next;
    logic [tfm_pkg::GUARD_W-1:0] guard_reg, guard_next;
    logic [7:0]                  char_reg, char_next;
    logic                        last_reg, last_next;
    tfm_pkg::out_t               res_reg, res_next;
    logic                        m_valid_reg, m_valid_next;
    tfm_pkg::out_t               m_data_reg, m_data_next;

    logic                        ram_we;
    logic [tfm_pkg::ADDR_W-1:0]  ram_waddr;
    logic [7:0]                  ram_rdata;
    logic [tfm_pkg::LEN_W-1:0]   len_base;
    logic                        finish;
    tfm_pkg::out_t               res_now;

    // filter character store, read address follows the next filter position
    tfm_ram #(
        .WIDTH (8),
        .DEPTH (tfm_pkg::FILTER_MAX)
    ) u_filter_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.char_code),
        .raddr (pos_next[tfm_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // load, match step and result sequencing
    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        load_open_next = load_open_reg;
        pos_next       = pos_reg;
        skip_next      = skip_reg;
        verdict_next   = verdict_reg;
        guard_next     = guard_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        len_base       = load_open_reg ? len_reg : '0;
        ram_waddr      = len_base[tfm_pkg::ADDR_W-1:0];
        finish         = 1'b0;
        res_now        = '0;

        // result register drains
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.action == tfm_pkg::ACT_LOAD) begin
                        // store one filter character, extra ones are dropped
                        if (len_base < tfm_pkg::LEN_W'(tfm_pkg::FILTER_MAX)) begin
                            ram_we   = 1'b1;
                            len_next = len_base + 1'b1;
                        end else begin
                            len_next = len_base;
                        end
                        load_open_next = !s_data.last;
                        pos_next       = '0;
                        skip_next      = 1'b0;
                        verdict_next   = tfm_pkg::VERDICT_OPEN;
                    end else begin
                        char_next  = s_data.char_code;
                        last_next  = s_data.last;
                        guard_next = '0;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (verdict_reg != tfm_pkg::VERDICT_OPEN ||
                    guard_reg == tfm_pkg::GUARD_W'(tfm_pkg::GUARD_LIMIT)) begin
                    finish = 1'b1;
                end else begin
                    guard_next = guard_reg + 1'b1;
                    if (skip_reg) begin
                        // plus passes over bytes up to the next slash
                        if (char_reg != tfm_pkg::CH_SLASH) begin
                            finish = 1'b1;
                        end else begin
                            skip_next = 1'b0;
                        end
                    end else if (pos_reg >= len_reg) begin
                        verdict_next = tfm_pkg::VERDICT_NOMATCH;
                        finish       = 1'b1;
                    end else begin
                        case (ram_rdata)
                            tfm_pkg::CH_PLUS: begin
                                pos_next  = pos_reg + 1'b1;
                                skip_next = 1'b1;
                            end
                            tfm_pkg::CH_HASH: begin
                                verdict_next = (pos_reg + 1'b1 == len_reg) ?
                                    tfm_pkg::VERDICT_MATCH : tfm_pkg::VERDICT_INVALID;
                                finish = 1'b1;
                            end
                            default: begin
                                if (ram_rdata == char_reg) begin
                                    pos_next = pos_reg + 1'b1;
                                end else begin
                                    verdict_next = tfm_pkg::VERDICT_NOMATCH;
                                end
                                finish = 1'b1;
                            end
                        endcase
                    end
                end

                // end of this byte, give a result on the last topic byte
                if (finish) begin
                    res_now.matched = (verdict_next == tfm_pkg::VERDICT_MATCH) ||
                                      (verdict_next == tfm_pkg::VERDICT_OPEN &&
                                       pos_next == len_reg);
                    res_now.invalid_filter = (verdict_next == tfm_pkg::VERDICT_INVALID);
                    if (last_reg) begin
                        pos_next     = '0;
                        skip_next    = 1'b0;
                        verdict_next = tfm_pkg::VERDICT_OPEN;
                        if (!m_valid_reg || m_ready) begin
                            m_valid_next = 1'b1;
                            m_data_next  = res_now;
                            state_next   = ST_IDLE;
                        end else begin
                            res_next   = res_now;
                            state_next = ST_DONE;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            load_open_reg <= 1'b0;
            pos_reg       <= '0;
            skip_reg      <= 1'b0;
            verdict_reg   <= tfm_pkg::VERDICT_OPEN;
            guard_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            load_open_reg <= load_open_next;
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
            verdict_reg   <= verdict_next;
            guard_reg     <= guard_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        char_reg   <= char_next;
        last_reg   <= last_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // match position never passes the stored filter length
    a_pos_in_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= len_reg)
        else $error("filter position beyond filter length");

    // a held result means the output register is occupied
    a_done_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> m_valid_reg)
        else $error("pending result with empty output register");

    // match steps per byte stay within the bound
    a_guard_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        guard_reg <= tfm_pkg::GUARD_W'(tfm_pkg::GUARD_LIMIT))
        else $error("match step count out of range");

    // stored length never exceeds the filter capacity
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= tfm_pkg::LEN_W'(tfm_pkg::FILTER_MAX))
        else $error("filter length out of range");

endmodule

`default_nettype wire

FILE: sv/tfm_ram.sv
// tfm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench: self-checking bench for topic_filter_wildcard_match_unit
// loads filters and streams topics, predicts each verdict and checks every result
// depends on tfm_pkg and the unit's rtl
`timescale 1ns / 100ps

module testbench;
    import tfm_pkg::*;

    localparam int ITEM_COUNT = 1550;
    localparam int TAIL_ITEMS = 150;
    localparam int DRAIN_CYCLES = 60;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    topic_filter_wildcard_match_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // pending input transactions and expected verdicts
    in_t  pending_chars[$];
    out_t expected_verdicts[$];
    logic [7:0] filter_buf[$];
    logic [7:0] topic_bytes[$];
    logic [7:0] byte_buf[$];

    int fault_count = 0;
    int accepted_count = 0;
    int result_count = 0;
    int src_gap = 0;
    int snk_gap = 0;
    logic tail_calm = 1'b0;

    // predictor copy of the unit's state
    logic [7:0]       flt_chars [FILTER_MAX];
    logic [LEN_W-1:0] flt_len = '0;
    logic             flt_loading = 1'b0;
    logic [LEN_W-1:0] flt_pos = '0;
    logic             lvl_skip = 1'b0;
    logic [1:0]       match_state = VERDICT_OPEN;

    function void restart_match();
        flt_pos = '0;
        lvl_skip = 1'b0;
        match_state = VERDICT_OPEN;
    endfunction

    // advance the match by one topic byte; plus may take several steps
    function void match_topic_byte(logic [7:0] c);
        int guard;
        guard = 0;
        while (match_state == VERDICT_OPEN && guard < GUARD_LIMIT) begin
            guard++;
            if (lvl_skip) begin
                if (c != CH_SLASH)
                    return;
                lvl_skip = 1'b0;
                continue;
            end
            if (flt_pos >= flt_len || flt_pos >= FILTER_MAX) begin
                match_state = VERDICT_NOMATCH;
                return;
            end
            if (flt_chars[flt_pos[ADDR_W-1:0]] == CH_PLUS) begin
                flt_pos++;
                lvl_skip = 1'b1;
            end else if (flt_chars[flt_pos[ADDR_W-1:0]] == CH_HASH) begin
                match_state = (flt_pos + 1 == flt_len) ? VERDICT_MATCH : VERDICT_INVALID;
                return;
            end else if (flt_chars[flt_pos[ADDR_W-1:0]] == c) begin
                flt_pos++;
                return;
            end else begin
                match_state = VERDICT_NOMATCH;
                return;
            end
        end
    endfunction

    // update the predicted state for one accepted transaction
    function void predict_transaction(in_t d);
        out_t r;
        if (d.action == ACT_LOAD) begin
            if (!flt_loading) begin
                flt_len = '0;
                flt_loading = 1'b1;
            end
            if (flt_len < FILTER_MAX) begin
                flt_chars[flt_len[ADDR_W-1:0]] = d.char_code;
                flt_len++;
            end
            if (d.last)
                flt_loading = 1'b0;
            restart_match();
        end else begin
            match_topic_byte(d.char_code);
            if (d.last) begin
                r.matched = (match_state == VERDICT_MATCH) ||
                            (match_state == VERDICT_OPEN && flt_pos == flt_len);
                r.invalid_filter = (match_state == VERDICT_INVALID);
                expected_verdicts.push_back(r);
                restart_match();
            end
        end
    endfunction

    // stimulus helpers
    task send_char(logic act, logic [7:0] ch, logic lst);
        in_t d;
        d.action = act;
        d.char_code = ch;
        d.last = lst;
        pending_chars.push_back(d);
    endtask

    task send_bytes(logic act, bit close);
        for (int i = 0; i < byte_buf.size(); i++)
            send_char(act, byte_buf[i], close && (i == byte_buf.size() - 1));
    endtask

    task send_string(logic act, string s);
        byte_buf.delete();
        for (int i = 0; i < s.len(); i++)
            byte_buf.push_back(s[i]);
        send_bytes(act, 1'b1);
    endtask

    // character mix that favors the special characters
    function logic [7:0] pick_char();
        logic [7:0] ch;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ch = 8'(8'h61 + $urandom_range(0, 2));
            4, 5:       ch = CH_SLASH;
            6, 7:       ch = CH_PLUS;
            8:          ch = CH_HASH;
            default:    ch = 8'($urandom_range(0, 255));
        endcase
        return ch;
    endfunction

    task build_filter();
        int n;
        if ($urandom_range(0, 19) == 0)
            n = $urandom_range(FILTER_MAX - 2, FILTER_MAX + 8);
        else
            n = $urandom_range(1, 8);
        filter_buf.delete();
        for (int i = 0; i < n; i++)
            filter_buf.push_back(pick_char());
        if ($urandom_range(0, 2) == 0)
            filter_buf.push_back(CH_HASH);
    endtask

    // topic that follows the filter, sometimes damaged
    task build_topic();
        int k;
        topic_bytes.delete();
        if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++)
                topic_bytes.push_back(pick_char());
        end else begin
            foreach (filter_buf[i]) begin
                if (filter_buf[i] == CH_PLUS) begin
                    k = $urandom_range(0, 2);
                    for (int j = 0; j < k; j++)
                        topic_bytes.push_back(8'(8'h61 + $urandom_range(0, 2)));
                end else if (filter_buf[i] == CH_HASH) begin
                    k = $urandom_range(0, 3);
                    for (int j = 0; j < k; j++)
                        topic_bytes.push_back($urandom_range(0, 1) ? CH_SLASH : 8'h7A);
                end else begin
                    topic_bytes.push_back(filter_buf[i]);
                end
            end
            if (topic_bytes.size() == 0)
                topic_bytes.push_back(8'h61);
            case ($urandom_range(0, 7))
                0: topic_bytes[$urandom_range(0, topic_bytes.size() - 1)] = pick_char();
                1: topic_bytes.push_back(pick_char());
                2: if (topic_bytes.size() > 1) void'(topic_bytes.pop_back());
                default: ;
            endcase
        end
    endtask

    // stimulus: directed cases, then random sequences
    initial begin : stimulus
        int kind;
        int k;
        // empty filter after reset matches nothing
        send_char(ACT_TOPIC, 8'hFF, 1'b1);
        // plus needs at least one byte in its level
        send_string(ACT_LOAD, "a/+");
        send_string(ACT_TOPIC, "a/");
        send_string(ACT_TOPIC, "a/b");
        // hash does not cover the parent level
        send_string(ACT_LOAD, "a/#");
        send_string(ACT_TOPIC, "a");
        // hash that is not last
        send_string(ACT_LOAD, "#/");
        send_string(ACT_TOPIC, "x");
        // load abandons a topic in progress
        send_char(ACT_TOPIC, 8'h00, 1'b0);
        send_char(ACT_LOAD, CH_PLUS, 1'b1);
        // topic during an open load, then a final hash
        send_char(ACT_LOAD, 8'h00, 1'b0);
        send_char(ACT_TOPIC, 8'h00, 1'b1);
        send_char(ACT_LOAD, CH_HASH, 1'b1);
        send_char(ACT_TOPIC, 8'h00, 1'b0);
        send_char(ACT_TOPIC, 8'hFF, 1'b1);

        while (pending_chars.size() < ITEM_COUNT) begin
            kind = $urandom_range(0, 9);
            build_filter();
            if (kind < 7) begin
                // well-formed: filter then a few topics
                byte_buf = filter_buf;
                send_bytes(ACT_LOAD, 1'b1);
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) begin
                    build_topic();
                    byte_buf = topic_bytes;
                    send_bytes(ACT_TOPIC, 1'b1);
                end
            end else if (kind == 7) begin
                // noise
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                    send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end else if (kind == 8) begin
                // topic while the filter is still open
                k = $urandom_range(1, filter_buf.size());
                byte_buf.delete();
                for (int i = 0; i < k; i++)
                    byte_buf.push_back(filter_buf[i]);
                send_bytes(ACT_LOAD, 1'b0);
                build_topic();
                byte_buf = topic_bytes;
                send_bytes(ACT_TOPIC, 1'b1);
                send_char(ACT_LOAD, pick_char(), 1'b1);
                build_topic();
                byte_buf = topic_bytes;
                send_bytes(ACT_TOPIC, 1'b1);
            end else begin
                // topic cut short by a new filter
                build_topic();
                byte_buf = topic_bytes;
                send_bytes(ACT_TOPIC, 1'b0);
                byte_buf = filter_buf;
                send_bytes(ACT_LOAD, 1'b1);
                build_topic();
                byte_buf = topic_bytes;
                send_bytes(ACT_TOPIC, 1'b1);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // no idling near the end
        while (pending_chars.size() > TAIL_ITEMS)
            @(posedge aclk);
        tail_calm <= 1'b1;

        while (pending_chars.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0)
            $display("topic_filter_wildcard_match_unit regression: pass");
        else
            $display("topic_filter_wildcard_match_unit regression: fail");
        $finish;
    end

    // driver: presents pending transactions, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_transaction(s_data);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_chars.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!tail_calm && (accepted_count / 200) % 3 != 2 &&
                             $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 9);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data <= pending_chars.pop_front();
                end
            end
        end
    end

    task note_mismatch(string what, out_t want, out_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%t: %s: expected matched=%0d invalid=%0d, got matched=%0d invalid=%0d",
                     $realtime, what, want.matched, want.invalid_filter,
                     got.matched, got.invalid_filter);
    endtask

    // monitor: checks each result transaction, stalls at random
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_verdicts.size() == 0) begin
                    want = 'x;
                    note_mismatch("unexpected result", want, m_data);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_data.matched !== want.matched ||
                        m_data.invalid_filter !== want.invalid_filter)
                        note_mismatch("wrong result", want, m_data);
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if (!tail_calm && (result_count / 60) % 3 != 1 &&
                         $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("topic_filter_wildcard_match_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/tfm_pkg.sv
sv/tfm_ram.sv
sv/topic_filter_wildcard_match_unit.sv
bench/testbench.sv
